>>> hdl/hlle_pkg.sv
// Shared types and constants of the handle linked list engine.
`default_nettype none

package hlle_pkg;

    localparam int HANDLE_COUNT = 1024;
    localparam int HANDLE_W     = $clog2(HANDLE_COUNT);
    localparam int FREE_W       = HANDLE_W + 1;
    localparam int VALUE_W      = 32;

    typedef enum logic [2:0] {
        CMD_INS_HEAD   = 3'd0,
        CMD_INS_TAIL   = 3'd1,
        CMD_INS_AFTER  = 3'd2,
        CMD_INS_BEFORE = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_MOVE_HEAD  = 3'd5,
        CMD_MOVE_TAIL  = 3'd6,
        CMD_QUERY      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_DEAD = 2'd1,
        STS_FULL = 2'd2
    } sts_t;

    // One write to each link table per cycle; address 0 lands in the sentinel registers.
    typedef struct packed {
        logic                f_we;
        logic [HANDLE_W-1:0] f_addr;
        logic [HANDLE_W-1:0] f_data;
        logic                b_we;
        logic [HANDLE_W-1:0] b_addr;
        logic [HANDLE_W-1:0] b_data;
    } link_wr_t;

    typedef struct packed {
        logic                val_we;
        logic                live_we;
        logic                live_data;
        logic [HANDLE_W-1:0] addr;
        logic [VALUE_W-1:0]  value;
    } node_wr_t;

endpackage

`default_nettype wire

>>> hdl/hlle_link_store.sv
// Forward and backward link tables with the sentinel links held in registers.
`default_nettype none

module hlle_link_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hlle_pkg::HANDLE_W-1:0] rd_addr,
    input  hlle_pkg::link_wr_t            wr,
    output logic [hlle_pkg::HANDLE_W-1:0] rd_fwd,
    output logic [hlle_pkg::HANDLE_W-1:0] rd_bwd,
    output logic [hlle_pkg::HANDLE_W-1:0] head_fwd,
    output logic [hlle_pkg::HANDLE_W-1:0] head_bwd
);
    import hlle_pkg::*;

    logic [HANDLE_W-1:0] f_mem [HANDLE_COUNT];
    logic [HANDLE_W-1:0] b_mem [HANDLE_COUNT];
    logic [HANDLE_W-1:0] f_rd_reg;
    logic [HANDLE_W-1:0] b_rd_reg;
    logic                rd_zero_reg;
    logic [HANDLE_W-1:0] head_fwd_reg;
    logic [HANDLE_W-1:0] head_bwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.f_we && wr.f_addr != '0)
        begin
            f_mem[wr.f_addr] <= wr.f_data;
        end
        if (wr.b_we && wr.b_addr != '0)
        begin
            b_mem[wr.b_addr] <= wr.b_data;
        end
        f_rd_reg <= f_mem[rd_addr];
        b_rd_reg <= b_mem[rd_addr];
    end

    // An empty list has the sentinel pointing at itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_fwd_reg <= '0;
            head_bwd_reg <= '0;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            if (wr.f_we && wr.f_addr == '0)
            begin
                head_fwd_reg <= wr.f_data;
            end
            if (wr.b_we && wr.b_addr == '0)
            begin
                head_bwd_reg <= wr.b_data;
            end
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    assign rd_fwd   = rd_zero_reg ? head_fwd_reg : f_rd_reg;
    assign rd_bwd   = rd_zero_reg ? head_bwd_reg : b_rd_reg;
    assign head_fwd = head_fwd_reg;
    assign head_bwd = head_bwd_reg;

endmodule

`default_nettype wire

>>> hdl/hlle_node_store.sv
// Value and live flag tables, indexed by handle.
`default_nettype none

module hlle_node_store (
    input  logic                          clk,
    input  logic [hlle_pkg::HANDLE_W-1:0] rd_addr,
    input  hlle_pkg::node_wr_t            wr,
    output logic [hlle_pkg::VALUE_W-1:0]  rd_value,
    output logic                          rd_live
);
    import hlle_pkg::*;

    logic [VALUE_W-1:0] val_mem  [HANDLE_COUNT];
    logic               live_mem [HANDLE_COUNT];
    logic [VALUE_W-1:0] val_rd_reg;
    logic               live_rd_reg;

    // Only handles below the free counter were ever written, so the caller
    // qualifies the live flag with that bound instead of clearing the table.
    always_ff @(posedge clk)
    begin
        if (wr.val_we)
        begin
            val_mem[wr.addr] <= wr.value;
        end
        if (wr.live_we)
        begin
            live_mem[wr.addr] <= wr.live_data;
        end
        val_rd_reg  <= val_mem[rd_addr];
        live_rd_reg <= live_mem[rd_addr];
    end

    assign rd_value = val_rd_reg;
    assign rd_live  = live_rd_reg;

endmodule

`default_nettype wire

>>> hdl/handle_linked_list_engine.sv
// Top level: command sequencer of the handle linked list engine.
// The engine keeps a circular doubly linked list whose nodes are named by
// handles; handle 0 is the head sentinel and new handles count up from 1.
// Commands enter on the command channel (cmd_valid/cmd_ready with command,
// key_handle and item_value) and each gives exactly one item on the response
// channel (rsp_valid/rsp_ready with status and the query fields).
// One command is worked on at a time. After acceptance a query or any rejected
// command passes the read and evaluate steps to the done step; a delete adds
// the unlink step, an insert the link and splice steps and a move all three.
// A new command is taken in the cycle after the response is loaded. The steps
// are set by the link tables, which take one read and one write per cycle each:
// a move needs a read pass and three write passes over them.
// The response sits in an output register; if the receiver stalls, a finished
// command waits in its last step and the engine takes no new item until the
// old response is taken. Reset empties the list and restarts handles at 1;
// it needs no clearing pass.
`default_nettype none

module handle_linked_list_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [2:0]                    command,
    input  logic [hlle_pkg::HANDLE_W-1:0] key_handle,
    input  logic [hlle_pkg::VALUE_W-1:0]  item_value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [1:0]                    status,
    output logic [hlle_pkg::HANDLE_W-1:0] new_handle,
    output logic [hlle_pkg::VALUE_W-1:0]  read_value,
    output logic [hlle_pkg::HANDLE_W-1:0] next_handle,
    output logic [hlle_pkg::HANDLE_W-1:0] prev_handle
);
    import hlle_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_UNLINK = 7'b0001000,
        S_LINK   = 7'b0010000,
        S_SPLICE = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg,   state_next;
    cmd_t                cmd_reg,     cmd_next;
    logic [HANDLE_W-1:0] key_reg,     key_next;
    logic [VALUE_W-1:0]  val_reg,     val_next;
    logic [FREE_W-1:0]   free_reg,    free_next;
    logic [HANDLE_W-1:0] at_reg,      at_next;
    logic [HANDLE_W-1:0] lx_reg,      lx_next;
    logic [HANDLE_W-1:0] nd_reg,      nd_next;
    logic [HANDLE_W-1:0] p_reg,       p_next;
    logic [HANDLE_W-1:0] x_reg,       x_next;
    sts_t                res_sts_reg, res_sts_next;
    logic [HANDLE_W-1:0] res_nh_reg,  res_nh_next;
    logic [VALUE_W-1:0]  res_rv_reg,  res_rv_next;
    logic [HANDLE_W-1:0] res_nx_reg,  res_nx_next;
    logic [HANDLE_W-1:0] res_pv_reg,  res_pv_next;
    logic                rsp_valid_reg, rsp_valid_next;
    sts_t                rsp_sts_reg, rsp_sts_next;
    logic [HANDLE_W-1:0] rsp_nh_reg,  rsp_nh_next;
    logic [VALUE_W-1:0]  rsp_rv_reg,  rsp_rv_next;
    logic [HANDLE_W-1:0] rsp_nx_reg,  rsp_nx_next;
    logic [HANDLE_W-1:0] rsp_pv_reg,  rsp_pv_next;

    link_wr_t            link_wr;
    node_wr_t            node_wr;
    logic [HANDLE_W-1:0] rd_fwd;
    logic [HANDLE_W-1:0] rd_bwd;
    logic [HANDLE_W-1:0] head_fwd;
    logic [HANDLE_W-1:0] head_bwd;
    logic [VALUE_W-1:0]  rd_value;
    logic                rd_live;

    logic                is_sent;
    logic                is_live;
    logic                full;
    logic                is_insert;
    logic                load_rsp;
    logic [HANDLE_W-1:0] ins_at;
    logic [HANDLE_W-1:0] ins_x;

    hlle_link_store u_links (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (key_reg),
        .wr       (link_wr),
        .rd_fwd   (rd_fwd),
        .rd_bwd   (rd_bwd),
        .head_fwd (head_fwd),
        .head_bwd (head_bwd)
    );

    hlle_node_store u_nodes (
        .clk      (clk),
        .rd_addr  (key_reg),
        .wr       (node_wr),
        .rd_value (rd_value),
        .rd_live  (rd_live)
    );

    assign is_sent   = (key_reg == '0);
    assign is_live   = !is_sent && ({1'b0, key_reg} < free_reg) && rd_live;
    assign full      = (free_reg >= FREE_W'(HANDLE_COUNT));
    assign is_insert = (cmd_reg == CMD_INS_HEAD) || (cmd_reg == CMD_INS_TAIL) ||
                       (cmd_reg == CMD_INS_AFTER) || (cmd_reg == CMD_INS_BEFORE);
    assign load_rsp  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Neighbors of a new node, taken from the state before the insert.
    always_comb
    begin
        case (cmd_reg)
            CMD_INS_HEAD:
            begin
                ins_at = '0;
                ins_x  = head_fwd;
            end
            CMD_INS_TAIL:
            begin
                ins_at = head_bwd;
                ins_x  = '0;
            end
            CMD_INS_AFTER:
            begin
                ins_at = key_reg;
                ins_x  = rd_fwd;
            end
            CMD_INS_BEFORE:
            begin
                ins_at = rd_bwd;
                ins_x  = key_reg;
            end
            default:
            begin
                ins_at = '0;
                ins_x  = '0;
            end
        endcase
    end

    // Table writes of each step.
    always_comb
    begin
        link_wr = '0;
        node_wr = '0;
        node_wr.addr  = free_reg[HANDLE_W-1:0];
        node_wr.value = val_reg;
        case (state_reg)
            S_EVAL:
            begin
                if (is_insert && (is_live || is_sent || cmd_reg == CMD_INS_HEAD ||
                                  cmd_reg == CMD_INS_TAIL) && !full)
                begin
                    node_wr.val_we    = 1'b1;
                    node_wr.live_we   = 1'b1;
                    node_wr.live_data = 1'b1;
                end
                else if (cmd_reg == CMD_DELETE && is_live)
                begin
                    node_wr.live_we   = 1'b1;
                    node_wr.live_data = 1'b0;
                    node_wr.addr      = key_reg;
                end
            end
            S_UNLINK:
            begin
                link_wr.f_we   = 1'b1;
                link_wr.f_addr = p_reg;
                link_wr.f_data = x_reg;
                link_wr.b_we   = 1'b1;
                link_wr.b_addr = x_reg;
                link_wr.b_data = p_reg;
            end
            S_LINK:
            begin
                link_wr.b_we   = 1'b1;
                link_wr.b_addr = nd_reg;
                link_wr.b_data = at_reg;
                link_wr.f_we   = 1'b1;
                link_wr.f_addr = nd_reg;
                link_wr.f_data = lx_reg;
            end
            S_SPLICE:
            begin
                link_wr.b_we   = 1'b1;
                link_wr.b_addr = lx_reg;
                link_wr.b_data = nd_reg;
                link_wr.f_we   = 1'b1;
                link_wr.f_addr = at_reg;
                link_wr.f_data = nd_reg;
            end
            default:
            begin
                link_wr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        free_next      = free_reg;
        at_next        = at_reg;
        lx_next        = lx_reg;
        nd_next        = nd_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        res_sts_next   = res_sts_reg;
        res_nh_next    = res_nh_reg;
        res_rv_next    = res_rv_reg;
        res_nx_next    = res_nx_reg;
        res_pv_next    = res_pv_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_sts_next   = rsp_sts_reg;
        rsp_nh_next    = rsp_nh_reg;
        rsp_rv_next    = rsp_rv_reg;
        rsp_nx_next    = rsp_nx_reg;
        rsp_pv_next    = rsp_pv_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    key_next   = key_handle;
                    val_next   = item_value;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                res_sts_next = STS_OK;
                res_nh_next  = '0;
                res_rv_next  = '0;
                res_nx_next  = '0;
                res_pv_next  = '0;
                p_next       = rd_bwd;
                x_next       = rd_fwd;
                nd_next      = key_reg;
                at_next      = ins_at;
                lx_next      = ins_x;
                state_next   = S_DONE;
                case (cmd_reg)
                    CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_INS_BEFORE:
                    begin
                        if ((cmd_reg == CMD_INS_AFTER || cmd_reg == CMD_INS_BEFORE) &&
                            !(is_live || is_sent))
                        begin
                            res_sts_next = STS_DEAD;
                        end
                        else if (full)
                        begin
                            res_sts_next = STS_FULL;
                        end
                        else
                        begin
                            nd_next     = free_reg[HANDLE_W-1:0];
                            res_nh_next = free_reg[HANDLE_W-1:0];
                            free_next   = free_reg + FREE_W'(1);
                            state_next  = S_LINK;
                        end
                    end
                    CMD_DELETE, CMD_MOVE_HEAD, CMD_MOVE_TAIL:
                    begin
                        if (is_live)
                        begin
                            state_next = S_UNLINK;
                        end
                        else
                        begin
                            res_sts_next = STS_DEAD;
                        end
                    end
                    CMD_QUERY:
                    begin
                        // The sentinel reads back the first and last handles.
                        if (is_live || is_sent)
                        begin
                            res_rv_next = is_live ? rd_value : '0;
                            res_nx_next = rd_fwd;
                            res_pv_next = rd_bwd;
                        end
                        else
                        begin
                            res_sts_next = STS_DEAD;
                        end
                    end
                    default:
                    begin
                        res_sts_next = STS_DEAD;
                    end
                endcase
            end
            S_UNLINK:
            begin
                // Relink point as it stands once the node is taken out.
                if (cmd_reg == CMD_MOVE_HEAD)
                begin
                    at_next    = '0;
                    lx_next    = (p_reg == '0) ? x_reg : head_fwd;
                    state_next = S_LINK;
                end
                else if (cmd_reg == CMD_MOVE_TAIL)
                begin
                    at_next    = (x_reg == '0) ? p_reg : head_bwd;
                    lx_next    = '0;
                    state_next = S_LINK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                state_next = S_SPLICE;
            end
            S_SPLICE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_sts_next   = res_sts_reg;
                    rsp_nh_next    = res_nh_reg;
                    rsp_rv_next    = res_rv_reg;
                    rsp_nx_next    = res_nx_reg;
                    rsp_pv_next    = res_pv_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= FREE_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        at_reg      <= at_next;
        lx_reg      <= lx_next;
        nd_reg      <= nd_next;
        p_reg       <= p_next;
        x_reg       <= x_next;
        res_sts_reg <= res_sts_next;
        res_nh_reg  <= res_nh_next;
        res_rv_reg  <= res_rv_next;
        res_nx_reg  <= res_nx_next;
        res_pv_reg  <= res_pv_next;
        rsp_sts_reg <= rsp_sts_next;
        rsp_nh_reg  <= rsp_nh_next;
        rsp_rv_reg  <= rsp_rv_next;
        rsp_nx_reg  <= rsp_nx_next;
        rsp_pv_reg  <= rsp_pv_next;
    end

    assign cmd_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_sts_reg;
    assign new_handle  = rsp_nh_reg;
    assign read_value  = rsp_rv_reg;
    assign next_handle = rsp_nx_reg;
    assign prev_handle = rsp_pv_reg;

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg != '0 && free_reg <= FREE_W'(HANDLE_COUNT))
        else $error("free handle counter out of range");

    a_free_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EVAL |=> $stable(free_reg))
        else $error("free handle counter moved outside evaluation");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STS_OK |-> new_handle == '0 && read_value == '0)
        else $error("rejected command carries data");

    a_handle_issued: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && new_handle != '0 |-> {1'b0, new_handle} < free_reg)
        else $error("reported handle was never issued");
`endif

endmodule

`default_nettype wire
